>>> src/set_assoc_cache_lru_sim_macros.svh
// Assertion macros for the set-associative LRU cache model.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define SACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sacl assertion failed");
// Next-cycle implication, disabled while reset is low
`define SACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sacl assertion failed");
`else
`define SACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/sacl_pkg.sv
// Shared types, constants and helpers of the set-associative LRU cache model.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none
package sacl_pkg;

    // Geometry
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    // Field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 64;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int OUTC_W    = 2;
    localparam int SHIFT_W   = $clog2(ADDR_W) + 1;

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_SBITS_W  = 3;
    localparam int CFG_OFFSET_W = 6;
    localparam int CFG_WAYS_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_OTHER  = 2'd3
    } t_op;

    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT     = 2'd0,
        OUT_MISS    = 2'd1,
        OUT_EVICT   = 2'd2,
        OUT_IGNORED = 2'd3
    } t_outcome;

    // One cache line and one set row as stored in the line memory
    typedef struct packed {
        logic               vld;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        t_outcome           outcome;
        logic               extra_hit;
        logic [CNT_W-1:0]   hit_count;
        logic [CNT_W-1:0]   miss_count;
        logic [CNT_W-1:0]   evict_count;
        logic               clock_overflow;
    } t_result;

    // Saturating increment of a 32-bit counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

>>> src/sacl_if.sv
// Valid/ready channel interfaces: access input, result output and register writes.
// Depends on sacl_pkg for field widths.
`default_nettype none

interface sacl_acc_if;
    import sacl_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface sacl_res_if;
    import sacl_pkg::*;
    logic              valid;
    logic              ready;
    logic [OUTC_W-1:0] outcome;
    logic              extra_hit;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  evict_count;
    logic              clock_overflow;

    modport source (output valid, output outcome, output extra_hit, output hit_count,
                    output miss_count, output evict_count, output clock_overflow,
                    input ready);
    modport sink   (input valid, input outcome, input extra_hit, input hit_count,
                    input miss_count, input evict_count, input clock_overflow,
                    output ready);
endinterface

interface sacl_cfg_if;
    import sacl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/sacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sacl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> src/set_assoc_cache_lru_sim.sv
// Top level of the set-associative LRU cache model: access decode, set lookup,
// replacement and statistics. Depends on sacl_pkg, sacl_if.sv and sacl_ram.
//
// Usage:
//   i_acc carries one memory access per transaction (opcode, 64-bit address).
//   o_res returns exactly one result per access: outcome, modify extra hit,
//   the saturating hit/miss/eviction totals and the sticky clock overflow flag.
//   i_cfg writes set_index_bits (0), offset_bits (1) and ways_in_use (2); it is
//   always ready, and writes are expected only while no access is in flight.
// Timing:
//   An access is accepted in the idle cycle, where the set row is read from the
//   line memory. In the next cycle the ways are compared, the victim is chosen
//   and the row is written back, and the result register loads at its end.
//   The result is valid on o_res once the result register loads; no new access is
//   taken until the read-modify-write of the current set row is done.
//   The next access may be accepted while a result still waits on o_res; if the
//   receiver stalls, the write-back cycle holds until the result register frees.
// Reset:
//   Synchronous, active low. Totals, access clock and flags clear, the config
//   returns to 0/0/1, and a per-set row-valid flag marks every line invalid at
//   once, so no clearing pass runs and accesses are taken right after reset.
`default_nettype none
`include "set_assoc_cache_lru_sim_macros.svh"
module set_assoc_cache_lru_sim (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sacl_acc_if.sink    i_acc,
    sacl_res_if.source  o_res,
    sacl_cfg_if.sink    i_cfg
);
    import sacl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state                  r_state;
    logic [CFG_SBITS_W-1:0]  r_cfg_sbits;
    logic [CFG_OFFSET_W-1:0] r_cfg_offset;
    logic [CFG_WAYS_W-1:0]   r_cfg_ways;

    t_op                     r_op;
    logic [TAG_W-1:0]        r_tag;
    logic [SET_IDX_W-1:0]    r_set;
    logic [NUM_SETS-1:0]     r_row_vld;

    logic [STAMP_W-1:0]      r_clock;
    logic [CNT_W-1:0]        r_hit;
    logic [CNT_W-1:0]        r_miss;
    logic [CNT_W-1:0]        r_evict;
    logic                    r_ovf;
    logic                    r_out_valid;
    t_result                 r_res;

    logic [STAMP_W-1:0]      n_clock;
    logic [CNT_W-1:0]        n_hit;
    logic [CNT_W-1:0]        n_miss;
    logic [CNT_W-1:0]        n_evict;
    logic                    n_ovf;
    t_result                 n_res;

    logic                    acc_fire;
    logic                    out_free;
    logic                    eval_go;
    logic                    row_we;

    logic [CFG_SBITS_W-1:0]  sbits_eff;
    logic [CFG_WAYS_W-1:0]   ways_eff;
    logic [SET_IDX_W-1:0]    idx_mask;
    logic [ADDR_W-1:0]       addr_shr;
    logic [SET_IDX_W-1:0]    acc_set;
    logic [SHIFT_W-1:0]      tag_shift;
    logic [TAG_W-1:0]        acc_tag;

    logic [ROW_W-1:0]        ram_rdata;
    t_row                    rd_row;
    t_row                    wr_row;
    logic [MAX_WAYS-1:0]     way_used;
    logic [MAX_WAYS-1:0]     way_vld;
    logic [MAX_WAYS-1:0]     hit_vec;
    logic [MAX_WAYS-1:0]     empty_vec;
    logic [MAX_WAYS-1:0]     oldest_vec;
    logic [WAY_IDX_W-1:0]    hit_idx;
    logic [WAY_IDX_W-1:0]    empty_idx;
    logic [WAY_IDX_W-1:0]    victim_idx;
    logic [WAY_IDX_W-1:0]    sel_way;
    logic                    any_hit;
    logic                    any_empty;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_acc.ready = (r_state == S_IDLE);
    assign acc_fire    = i_acc.valid && i_acc.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign eval_go     = (r_state == S_EVAL) && out_free;
    assign row_we      = eval_go && (r_op != OP_OTHER);

    // Clamp the configured set width and way count
    always_comb begin
        sbits_eff = r_cfg_sbits;
        if (int'(r_cfg_sbits) > MAX_SET_BITS) begin
            sbits_eff = CFG_SBITS_W'(MAX_SET_BITS);
        end
        ways_eff = r_cfg_ways;
        if (r_cfg_ways == '0) begin
            ways_eff = CFG_WAYS_W'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            ways_eff = CFG_WAYS_W'(MAX_WAYS);
        end
    end

    // Split the incoming address into set index and tag
    always_comb begin
        for (int i = 0; i < SET_IDX_W; i++) begin
            idx_mask[i] = (i < int'(sbits_eff));
        end
        addr_shr  = i_acc.address >> r_cfg_offset;
        acc_set   = addr_shr[SET_IDX_W-1:0] & idx_mask;
        tag_shift = SHIFT_W'(r_cfg_offset) + SHIFT_W'(sbits_eff);
        acc_tag   = (int'(tag_shift) >= ADDR_W) ? '0 : (i_acc.address >> tag_shift);
    end

    // Line memory: one row per set, all ways side by side
    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_set),
        .i_wdata (wr_row),
        .i_re    (acc_fire),
        .i_raddr (acc_set),
        .o_rdata (ram_rdata)
    );

    assign rd_row = t_row'(ram_rdata);

    // Per-way match, empty and usage flags
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_used[w]  = (w < int'(ways_eff));
            way_vld[w]   = r_row_vld[r_set] && rd_row[w].vld;
            hit_vec[w]   = way_used[w] && way_vld[w] && (rd_row[w].tag == r_tag);
            empty_vec[w] = way_used[w] && !way_vld[w];
        end
    end

    // Oldest stamp among used ways: strictly older than lower ways, not newer than higher
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            oldest_vec[w] = way_used[w];
            for (int v = 0; v < MAX_WAYS; v++) begin
                if (v != w && way_used[v]) begin
                    if (v < w) begin
                        oldest_vec[w] = oldest_vec[w] && (rd_row[w].stamp < rd_row[v].stamp);
                    end else begin
                        oldest_vec[w] = oldest_vec[w] && (rd_row[w].stamp <= rd_row[v].stamp);
                    end
                end
            end
        end
    end

    // Lowest-index pick for hit, empty way and victim
    always_comb begin
        hit_idx    = '0;
        empty_idx  = '0;
        victim_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_IDX_W'(w);
            end
            if (empty_vec[w]) begin
                empty_idx = WAY_IDX_W'(w);
            end
            if (oldest_vec[w]) begin
                victim_idx = WAY_IDX_W'(w);
            end
        end
        any_hit   = |hit_vec;
        any_empty = |empty_vec;
    end

    // Update line, totals and result for the access in flight
    always_comb begin
        n_clock = sat_inc(r_clock);
        n_ovf   = r_ovf || (n_clock == '1);
        n_hit   = r_hit;
        n_miss  = r_miss;
        n_evict = r_evict;
        n_res   = '0;
        n_res.outcome = OUT_IGNORED;
        sel_way = victim_idx;
        for (int w = 0; w < MAX_WAYS; w++) begin
            wr_row[w]     = rd_row[w];
            wr_row[w].vld = way_vld[w];
        end
        if (r_op != OP_OTHER) begin
            if (any_hit) begin
                sel_way       = hit_idx;
                n_hit         = sat_inc(r_hit);
                n_res.outcome = OUT_HIT;
            end else if (any_empty) begin
                sel_way       = empty_idx;
                n_miss        = sat_inc(r_miss);
                n_res.outcome = OUT_MISS;
            end else begin
                n_miss        = sat_inc(r_miss);
                n_evict       = sat_inc(r_evict);
                n_res.outcome = OUT_EVICT;
            end
            wr_row[sel_way].vld   = 1'b1;
            wr_row[sel_way].tag   = r_tag;
            wr_row[sel_way].stamp = n_clock;
            if (r_op == OP_MODIFY) begin
                n_hit           = sat_inc(n_hit);
                n_res.extra_hit = 1'b1;
            end
        end
        n_res.hit_count      = n_hit;
        n_res.miss_count     = n_miss;
        n_res.evict_count    = n_evict;
        n_res.clock_overflow = n_ovf;
    end

    // State, configuration, statistics and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_sbits  <= '0;
            r_cfg_offset <= '0;
            r_cfg_ways   <= CFG_WAYS_W'(1);
            r_row_vld    <= '0;
            r_clock      <= '0;
            r_hit        <= '0;
            r_miss       <= '0;
            r_evict      <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_SET_BITS:    r_cfg_sbits  <= i_cfg.data[CFG_SBITS_W-1:0];
                    REG_OFFSET_BITS: r_cfg_offset <= i_cfg.data[CFG_OFFSET_W-1:0];
                    REG_WAYS:        r_cfg_ways   <= i_cfg.data[CFG_WAYS_W-1:0];
                    default: begin
                    end
                endcase
            end
            // Load a new result or drop the one just taken
            if (eval_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc_fire) begin
                        r_op    <= t_op'(i_acc.opcode);
                        r_tag   <= acc_tag;
                        r_set   <= acc_set;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (eval_go) begin
                        if (row_we) begin
                            r_row_vld[r_set] <= 1'b1;
                        end
                        r_clock     <= n_clock;
                        r_hit       <= n_hit;
                        r_miss      <= n_miss;
                        r_evict     <= n_evict;
                        r_ovf       <= n_ovf;
                        r_res       <= n_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result channel
    assign o_res.valid          = r_out_valid;
    assign o_res.outcome        = r_res.outcome;
    assign o_res.extra_hit      = r_res.extra_hit;
    assign o_res.hit_count      = r_res.hit_count;
    assign o_res.miss_count     = r_res.miss_count;
    assign o_res.evict_count    = r_res.evict_count;
    assign o_res.clock_overflow = r_res.clock_overflow;

    // Checks
    `SACL_ASSERT_NXT(a_acc_to_eval, i_clk, i_rst_n, acc_fire, r_state == S_EVAL)
    `SACL_ASSERT_NXT(a_eval_holds, i_clk, i_rst_n, (r_state == S_EVAL) && !out_free, (r_state == S_EVAL) && r_out_valid)
    `SACL_ASSERT_NXT(a_eval_loads, i_clk, i_rst_n, eval_go, r_out_valid && (r_state == S_IDLE))
    `SACL_ASSERT_NXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf, r_ovf)
    `SACL_ASSERT_NXT(a_hit_mono, i_clk, i_rst_n, 1'b1, r_hit >= $past(r_hit))

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU cache model set_assoc_cache_lru_sim.
// Depends on sacl_pkg, the channel interfaces in sacl_if.sv and the RTL top level.
module testbench;
    import sacl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 103;

    // LRU cache predictor plus the queue of results still owed by the block
    class cache_scoreboard;
        logic [2:0]         set_bits_cfg;
        logic [5:0]         offset_cfg;
        logic [3:0]         ways_cfg;
        bit                 line_vld[NUM_LINES];
        logic [TAG_W-1:0]   line_tag_q[NUM_LINES];
        logic [STAMP_W-1:0] line_age[NUM_LINES];
        logic [CNT_W-1:0]   access_ticks;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   evicts;
        bit                 ticks_overflowed;
        t_result            owed_results[$];
        int                 results_seen;
        int                 errors;

        function new();
            set_bits_cfg = '0;
            offset_cfg = '0;
            ways_cfg = 4'd1;
            foreach (line_vld[i]) line_vld[i] = 1'b0;
            access_ticks = '0;
            hits = '0;
            misses = '0;
            evicts = '0;
            ticks_overflowed = 1'b0;
            results_seen = 0;
            errors = 0;
        endfunction

        function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
            return (v == '1) ? v : v + 1;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SET_BITS:    set_bits_cfg = data[2:0];
                REG_OFFSET_BITS: offset_cfg = data[5:0];
                REG_WAYS:        ways_cfg = data[3:0];
                default: ;
            endcase
        endfunction

        // Look up one address, update the line store and the totals
        function t_outcome lookup(input logic [ADDR_W-1:0] addr);
            int unsigned idx_bits;
            int unsigned nways;
            int unsigned shift;
            int unsigned row;
            int unsigned base;
            int unsigned victim;
            logic [TAG_W-1:0] tag;
            idx_bits = (set_bits_cfg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_cfg;
            nways = (ways_cfg == 0) ? 1 : ways_cfg;
            if (nways > MAX_WAYS) nways = MAX_WAYS;
            shift = offset_cfg + idx_bits;
            row = 32'((addr >> offset_cfg) & ((64'd1 << idx_bits) - 64'd1));
            tag = (shift >= 64) ? '0 : (addr >> shift);
            base = (row % NUM_SETS) * MAX_WAYS;
            for (int w = 0; w < nways; w++) begin
                if (line_vld[base + w] && line_tag_q[base + w] == tag) begin
                    line_age[base + w] = access_ticks;
                    hits = bump(hits);
                    return OUT_HIT;
                end
            end
            for (int w = 0; w < nways; w++) begin
                if (!line_vld[base + w]) begin
                    line_vld[base + w] = 1'b1;
                    line_tag_q[base + w] = tag;
                    line_age[base + w] = access_ticks;
                    misses = bump(misses);
                    return OUT_MISS;
                end
            end
            // Replace the oldest stamp, lowest way on a tie
            victim = 0;
            for (int w = 1; w < nways; w++) begin
                if (line_age[base + w] < line_age[base + victim]) victim = w;
            end
            line_tag_q[base + victim] = tag;
            line_age[base + victim] = access_ticks;
            misses = bump(misses);
            evicts = bump(evicts);
            return OUT_EVICT;
        endfunction

        function void note_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
            t_result r;
            access_ticks = bump(access_ticks);
            if (access_ticks == '1) ticks_overflowed = 1'b1;
            r.outcome = OUT_IGNORED;
            r.extra_hit = 1'b0;
            if (op != OP_OTHER) begin
                r.outcome = lookup(addr);
                if (op == OP_MODIFY) begin
                    hits = bump(hits);
                    r.extra_hit = 1'b1;
                end
            end
            r.hit_count = hits;
            r.miss_count = misses;
            r.evict_count = evicts;
            r.clock_overflow = ticks_overflowed;
            owed_results.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [OUTC_W-1:0] outcome, input logic extra,
                                   input logic [CNT_W-1:0] hit_n,
                                   input logic [CNT_W-1:0] miss_n,
                                   input logic [CNT_W-1:0] evict_n, input logic ovf);
            t_result want;
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("result with no access pending: outcome %0d", outcome);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("outcome", 32'(want.outcome), 32'(outcome));
            compare_field("extra_hit", 32'(want.extra_hit), 32'(extra));
            compare_field("hit_count", want.hit_count, hit_n);
            compare_field("miss_count", want.miss_count, miss_n);
            compare_field("evict_count", want.evict_count, evict_n);
            compare_field("clock_overflow", 32'(want.clock_overflow), 32'(ovf));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sacl_acc_if acc();
    sacl_res_if res();
    sacl_cfg_if cfg();

    set_assoc_cache_lru_sim i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    cache_scoreboard sb = new;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int sent_total = 0;
    int cur_set_bits = 0;
    int cur_offset = 0;
    int cur_ways = 1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("set_assoc_cache_lru_sim verification failed");
        $finish;
    end

    // Randomly stall the result channel
    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Observe every transaction on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready)
                sb.check_result(res.outcome, res.extra_hit, res.hit_count, res.miss_count,
                                res.evict_count, res.clock_overflow);
            if (cfg.valid && cfg.ready)
                sb.write_reg(cfg.index, cfg.data);
            if (acc.valid && acc.ready)
                sb.note_access(acc.opcode, acc.address);
        end
    end

    // Present one access, hold it until taken, then maybe idle
    task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        acc.valid <= 1'b1;
        acc.opcode <= op;
        acc.address <= addr;
        @(posedge i_clk);
        while (!acc.ready) @(posedge i_clk);
        sent_total++;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            acc.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
    endtask

    task automatic wait_cfg_taken();
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
    endtask

    // Write all registers back to back; unused upper data bits get random values
    task automatic set_config(input int idx_width, input int offset, input int ways,
                              input bit poke_unused);
        cfg.valid <= 1'b1;
        cfg.index <= REG_SET_BITS;
        cfg.data <= {3'($urandom), 3'(idx_width)};
        wait_cfg_taken();
        cfg.index <= REG_OFFSET_BITS;
        cfg.data <= 6'(offset);
        wait_cfg_taken();
        cfg.index <= REG_WAYS;
        cfg.data <= {2'($urandom), 4'(ways)};
        wait_cfg_taken();
        if (poke_unused) begin
            cfg.index <= REG_UNUSED;
            cfg.data <= 6'($urandom);
            wait_cfg_taken();
        end
        cfg.valid <= 1'b0;
        cur_set_bits = (idx_width > MAX_SET_BITS) ? MAX_SET_BITS : idx_width;
        cur_offset = offset;
        cur_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
    endtask

    // Drop the access valid and wait until every result is back
    task automatic wait_drained();
        acc.valid <= 1'b0;
        while (sb.results_seen < sent_total) @(posedge i_clk);
    endtask

    // Compose an address from tag, set and offset under the current widths
    function automatic logic [ADDR_W-1:0] build_addr(input logic [TAG_W-1:0] tag,
                                                     input int unsigned row,
                                                     input logic [ADDR_W-1:0] low);
        logic [ADDR_W-1:0] a;
        int unsigned shift;
        shift = cur_offset + cur_set_bits;
        a = low & ((64'd1 << cur_offset) - 64'd1);
        a |= ((64'(row) & ((64'd1 << cur_set_bits) - 64'd1)) << cur_offset);
        if (shift < 64) a |= tag << shift;
        return a;
    endfunction

    // Mostly accesses to a small tag pool in a few sets, some fully random
    task automatic random_access(input logic [TAG_W-1:0] tag_base);
        logic [OP_W-1:0] op;
        logic [ADDR_W-1:0] addr;
        op = OP_W'($urandom_range(3));
        if ($urandom_range(99) < 85) begin
            if (op == OP_OTHER && $urandom_range(1)) op = OP_W'($urandom_range(2));
            addr = build_addr(tag_base ^ 64'($urandom_range(cur_ways + 2)),
                              $urandom_range(3), {$urandom, $urandom});
        end else begin
            addr = {$urandom, $urandom};
        end
        send_access(op, addr);
    endtask

    int set_bits_tbl[PHASES] = '{2, 0, 6, 3, 7, 1, 4, 5};
    int offset_tbl[PHASES]   = '{4, 0, 58, 63, 6, 12, 2, 30};
    int ways_tbl[PHASES]     = '{4, 1, 8, 2, 15, 0, 3, 6};

    initial begin
        logic [TAG_W-1:0] tag_base;
        i_rst_n <= 1'b0;
        acc.valid <= 1'b0;
        acc.opcode <= OP_LOAD;
        acc.address <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_SET_BITS;
        cfg.data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset widths: one set, one way, whole address is the tag
        send_access(OP_LOAD, 64'h0);
        send_access(OP_LOAD, 64'h0);
        send_access(OP_STORE, '1);
        send_access(OP_MODIFY, '1);
        send_access(OP_OTHER, 64'h5555_5555_5555_5555);
        send_access(OP_MODIFY, 64'h0);
        send_access(OP_LOAD, 64'h8000_0000_0000_0000);
        wait_drained();

        // Oversized set width and way count; tag shifted out completely
        set_config(7, 58, 15, 1'b1);
        send_access(OP_LOAD, '1);
        send_access(OP_LOAD, 64'hFC00_0000_0000_0000);
        send_access(OP_STORE, 64'h0);
        send_access(OP_MODIFY, 64'h03FF_FFFF_FFFF_FFFF);
        wait_drained();

        // Zero way count acts as one; tag is the top address bit
        set_config(0, 63, 0, 1'b0);
        send_access(OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
        send_access(OP_LOAD, '1);
        send_access(OP_OTHER, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();

        // Overfill one set to force least-recently-used replacement
        set_config(6, 0, 8, 1'b0);
        for (int t = 0; t < 9; t++) send_access(OP_LOAD, build_addr(64'(t), 5, '0));
        send_access(OP_LOAD, build_addr(64'd0, 5, '0));

        // Random phases under changing widths and idling patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            set_config(set_bits_tbl[ph], offset_tbl[ph], ways_tbl[ph], ph == 3);
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 83; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 83; end
                default: begin send_gap_pct = 35; stall_pct = 35; end
            endcase
            tag_base = {$urandom, $urandom};
            repeat (PHASE_LEN) random_access(tag_base);
        end

        // Drain and let any stray result show up
        stall_pct = 0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("set_assoc_cache_lru_sim verification clean");
        end else begin
            $display("set_assoc_cache_lru_sim verification failed");
        end
        $finish;
    end

endmodule

>>> set_assoc_cache_lru_sim.f
+incdir+src
src/sacl_pkg.sv
src/sacl_if.sv
src/sacl_ram.sv
src/set_assoc_cache_lru_sim.sv
verif/testbench.sv
